/* hdl/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared types and codes of the EV charge session sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ecs_pkg;

	localparam int unsigned LVL_W = 5;

	// Generator modes
	localparam logic [1:0] MODE_STOP = 2'd0;
	localparam logic [1:0] MODE_DC   = 2'd1;
	localparam logic [1:0] MODE_AC1K = 2'd2;
	localparam logic [1:0] MODE_ACCL = 2'd3;

	// Charge indicator codes
	localparam logic [1:0] LED_OFF   = 2'd0;
	localparam logic [1:0] LED_RED   = 2'd1;
	localparam logic [1:0] LED_GREEN = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_PLUGGED   = 2'd0;
	localparam logic [1:0] REG_S2_CLOSED = 2'd1;
	localparam logic [1:0] REG_UNPLUGGED = 2'd2;

	// Register reset values
	localparam logic signed [LVL_W-1:0] RST_PLUGGED_LEVEL   = 5'sd9;
	localparam logic signed [LVL_W-1:0] RST_S2_CLOSED_LEVEL = 5'sd6;
	localparam logic signed [LVL_W-1:0] RST_UNPLUGGED_LEVEL = 5'sd12;

	typedef struct packed {
		logic signed [LVL_W-1:0] plugged_level;
		logic signed [LVL_W-1:0] s2_closed_level;
		logic signed [LVL_W-1:0] unplugged_level;
	} cfg_t;

	typedef struct packed {
		logic                    start_request;
		logic                    stop_pressed;
		logic signed [LVL_W-1:0] measured_level;
	} sample_t;

	typedef struct packed {
		logic [1:0] pwm_mode;
		logic       contactor_closed;
		logic       hatch_locked;
		logic [1:0] charge_led;
		logic       plug_led;
		logic [2:0] phase_now;
		logic       battery_full;
	} result_t;

endpackage

`default_nettype wire

/* hdl/ecs_if.sv */
// ----------------------------------------------------------------------------
// ecs_sample_if / ecs_result_if
// Valid/ready channels for samples in and session results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecs_sample_if;
	logic              valid;
	logic              ready;
	logic              start_request;
	logic              stop_pressed;
	logic signed [4:0] measured_level;

	modport source (output valid, start_request, stop_pressed, measured_level,
		input ready);
	modport sink (input valid, start_request, stop_pressed, measured_level,
		output ready);
endinterface

interface ecs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] pwm_mode;
	logic       contactor_closed;
	logic       hatch_locked;
	logic [1:0] charge_led;
	logic       plug_led;
	logic [2:0] phase_now;
	logic       battery_full;

	modport source (output valid, pwm_mode, contactor_closed, hatch_locked,
		charge_led, plug_led, phase_now, battery_full, input ready);
	modport sink (input valid, pwm_mode, contactor_closed, hatch_locked,
		charge_led, plug_led, phase_now, battery_full, output ready);
endinterface

`default_nettype wire

/* hdl/ev_charge_session_fsm_core.sv */
// ----------------------------------------------------------------------------
// ev_charge_session_fsm_core
// EV charge station session sequencer, one result per pilot sample.
// ----------------------------------------------------------------------------
// Each sample transaction (start request, stop button, pilot level) moves the
// session phase machine by one tick and yields exactly one result transaction
// with the generator mode, contactor, hatch lock, LEDs, phase and a one-tick
// battery-full flag. A sample is held in the input register, then the phase
// update and the result are registered together once the result slot is
// free. A sample is taken every cycle as long as results are drained; a
// stalled result holds one sample in the input register before the sample
// channel backs up. Pilot levels are matched by exact equality against three
// configuration registers. The user is to write them only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ev_charge_session_fsm_core
	import ecs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [LVL_W-1:0]  wr_data,
	ecs_sample_if.sink             sample,
	ecs_result_if.source           result
);

	// Level thresholds
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plugged_level   <= RST_PLUGGED_LEVEL;
			cfg_q.s2_closed_level <= RST_S2_CLOSED_LEVEL;
			cfg_q.unplugged_level <= RST_UNPLUGGED_LEVEL;
		end else if (wr_en) begin
			case (wr_index)
				REG_PLUGGED:   cfg_q.plugged_level   <= wr_data;
				REG_S2_CLOSED: cfg_q.s2_closed_level <= wr_data;
				REG_UNPLUGGED: cfg_q.unplugged_level <= wr_data;
				default: ;  // no register there
			endcase
		end
	end

	// Input register stage
	logic    valid_s1;
	sample_t smp_s1;
	logic    out_valid_q;
	logic    out_free;
	logic    adv;
	logic    take;
	result_t res;

	// result slot is free when empty or being drained this cycle
	assign out_free     = !out_valid_q || result.ready;
	assign adv          = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;
	assign take         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s1.start_request  <= sample.start_request;
			smp_s1.stop_pressed   <= sample.stop_pressed;
			smp_s1.measured_level <= sample.measured_level;
		end
	end

	// Phase machine; its state registers double as the result payload
	ecs_session_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.smp    (smp_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.pwm_mode         = res.pwm_mode;
	assign result.contactor_closed = res.contactor_closed;
	assign result.hatch_locked     = res.hatch_locked;
	assign result.charge_led       = res.charge_led;
	assign result.plug_led         = res.plug_led;
	assign result.phase_now        = res.phase_now;
	assign result.battery_full     = res.battery_full;

	// A buffered sample that cannot move keeps its slot
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input stage lost a sample while stalled");

	// A sample that advances always shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result.valid)
		else $error("advanced sample produced no result");

	// Full-battery pulse only on the move into wait-open with DC on the pilot
	a_full_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.battery_full |-> (res.phase_now == 3'd5) && (res.pwm_mode == MODE_DC))
		else $error("battery_full outside end of charge");

	// Idle means contactor open and hatch locked
	a_idle_safe: assert property (@(posedge clk) disable iff (!arst_n)
		(res.phase_now == 3'd0) |-> !res.contactor_closed && res.hatch_locked)
		else $error("idle with contactor closed or hatch unlocked");

endmodule

`default_nettype wire

/* hdl/ecs_session_seq.sv */
// ----------------------------------------------------------------------------
// ecs_session_seq
// Session phase machine; its registers are also the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_session_seq
	import ecs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire sample_t smp,
	input  wire cfg_t    cfg,
	output result_t      res
);

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_WAIT_PLUG   = 3'd1,
		PH_LOCK        = 3'd2,
		PH_WAIT_S2     = 3'd3,
		PH_CHARGE      = 3'd4,
		PH_WAIT_OPEN   = 3'd5,
		PH_WAIT_UNPLUG = 3'd6
	} phase_t;

	phase_t     phase_q;
	logic [1:0] mode_q;
	logic       contactor_q;
	logic       lock_q;
	logic [1:0] charge_led_q;
	logic       plug_led_q;
	logic       full_q;

	logic lvl_plugged, lvl_s2_closed, lvl_unplugged;

	assign lvl_plugged   = (smp.measured_level == cfg.plugged_level);
	assign lvl_s2_closed = (smp.measured_level == cfg.s2_closed_level);
	assign lvl_unplugged = (smp.measured_level == cfg.unplugged_level);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			mode_q       <= MODE_STOP;
			contactor_q  <= 1'b0;
			lock_q       <= 1'b1;
			charge_led_q <= LED_OFF;
			plug_led_q   <= 1'b0;
			full_q       <= 1'b0;
		end else if (adv) begin
			full_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (smp.start_request) begin
						charge_led_q <= LED_RED;
						mode_q       <= MODE_DC;
						lock_q       <= 1'b0;
						phase_q      <= PH_WAIT_PLUG;
					end
				end
				PH_WAIT_PLUG: begin
					if (lvl_plugged) phase_q <= PH_LOCK;
				end
				PH_LOCK, PH_WAIT_S2, PH_CHARGE: begin
					if (smp.stop_pressed) begin
						// early stop wins over everything else this tick
						mode_q  <= MODE_DC;
						phase_q <= PH_WAIT_OPEN;
					end else if (phase_q == PH_LOCK) begin
						lock_q     <= 1'b1;
						plug_led_q <= 1'b1;
						mode_q     <= MODE_AC1K;
						phase_q    <= PH_WAIT_S2;
					end else if (phase_q == PH_WAIT_S2) begin
						contactor_q <= 1'b1;
						if (lvl_s2_closed) phase_q <= PH_CHARGE;
					end else if (lvl_plugged) begin
						full_q  <= 1'b1;
						mode_q  <= MODE_DC;
						phase_q <= PH_WAIT_OPEN;
					end else begin
						mode_q <= MODE_ACCL;
					end
				end
				PH_WAIT_OPEN: begin
					if (lvl_plugged) begin
						contactor_q  <= 1'b0;
						charge_led_q <= LED_GREEN;
						lock_q       <= 1'b0;
						phase_q      <= PH_WAIT_UNPLUG;
					end
				end
				PH_WAIT_UNPLUG: begin
					if (lvl_unplugged) begin
						lock_q       <= 1'b1;
						plug_led_q   <= 1'b0;
						charge_led_q <= LED_OFF;
						mode_q       <= MODE_STOP;
						phase_q      <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign res.pwm_mode         = mode_q;
	assign res.contactor_closed = contactor_q;
	assign res.hatch_locked     = lock_q;
	assign res.charge_led       = charge_led_q;
	assign res.plug_led         = plug_led_q;
	assign res.phase_now        = phase_q;
	assign res.battery_full     = full_q;

endmodule

`default_nettype wire
